// ----- sv/etok_pkg.sv -----
`timescale 1ns / 1ps
// etok_pkg: shared types, constants and helpers for the expression tokenizer.
// No dependencies; imported by every etok_* module and the top level.
package etok_pkg;

    localparam int VALUE_BITS = 32;
    localparam int POS_BITS   = 16;
    localparam int CH_BITS    = 8;
    localparam int KIND_BITS  = 4;
    localparam int CFG_BITS   = 16;

    localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};
    localparam logic [POS_BITS-1:0]   POS_MAX   = {POS_BITS{1'b1}};

    // queue depths between front, back and result port
    localparam int IQ_DEPTH    = 4;
    localparam int IQ_PTR_BITS = $clog2(IQ_DEPTH);
    localparam int IQ_CNT_BITS = $clog2(IQ_DEPTH + 1);
    localparam int TQ_DEPTH    = 4;
    localparam int TQ_PTR_BITS = $clog2(TQ_DEPTH);
    localparam int TQ_CNT_BITS = $clog2(TQ_DEPTH + 1);

    // action codes
    localparam logic ACT_CHAR = 1'b0;
    localparam logic ACT_END  = 1'b1;

    // configuration register indexes
    localparam logic REG_FIRST_LINE   = 1'b0;
    localparam logic REG_FIRST_COLUMN = 1'b1;

    // character codes
    localparam logic [CH_BITS-1:0] CH_LPAR    = 8'h28;
    localparam logic [CH_BITS-1:0] CH_RPAR    = 8'h29;
    localparam logic [CH_BITS-1:0] CH_PLUS    = 8'h2B;
    localparam logic [CH_BITS-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CH_BITS-1:0] CH_STAR    = 8'h2A;
    localparam logic [CH_BITS-1:0] CH_SLASH   = 8'h2F;
    localparam logic [CH_BITS-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [CH_BITS-1:0] CH_SPACE   = 8'h20;
    localparam logic [CH_BITS-1:0] CH_TAB     = 8'h09;
    localparam logic [CH_BITS-1:0] CH_CR      = 8'h0D;
    localparam logic [CH_BITS-1:0] CH_DIGIT0  = 8'h30;
    localparam logic [CH_BITS-1:0] CH_DIGIT9  = 8'h39;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_INT   = 4'd0,
        KIND_LPAR  = 4'd1,
        KIND_RPAR  = 4'd2,
        KIND_PLUS  = 4'd3,
        KIND_MINUS = 4'd4,
        KIND_MUL   = 4'd5,
        KIND_DIV   = 4'd6,
        KIND_END   = 4'd7,
        KIND_BAD   = 4'd8
    } t_kind;

    typedef enum logic [2:0] {
        CLS_DIGIT,
        CLS_OP,
        CLS_NEWLINE,
        CLS_SPACE,
        CLS_BAD,
        CLS_END
    } t_cls;

    // classified input item, front to back
    typedef struct packed {
        t_cls               cls;
        t_kind              kind;
        logic [CH_BITS-1:0] ch;
    } t_item;

    // one token, back to result port
    typedef struct packed {
        t_kind                 kind;
        logic [POS_BITS-1:0]   line;
        logic [POS_BITS-1:0]   column;
        logic [VALUE_BITS-1:0] value;
        logic [POS_BITS-1:0]   length;
        logic                  ovf;
        logic [CH_BITS-1:0]    bad_char;
        logic                  last;
    } t_token;

    function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
        return (v == POS_MAX) ? v : v + 1'b1;
    endfunction

endpackage

// ----- sv/etok_front.sv -----
`timescale 1ns / 1ps
// etok_front: classifies each incoming character and queues it for the back end.
// Depends on etok_pkg.
module etok_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    output logic                           o_full,
    input  logic                           i_action,
    input  logic [etok_pkg::CH_BITS-1:0]   i_ch,
    output logic                           o_item_valid,
    output etok_pkg::t_item                o_item,
    input  logic                           i_item_pop
);
    import etok_pkg::*;

    t_item                  r_mem [IQ_DEPTH];
    logic [IQ_PTR_BITS-1:0] r_wr_ptr;
    logic [IQ_PTR_BITS-1:0] r_rd_ptr;
    logic [IQ_CNT_BITS-1:0] r_count;
    t_item                  w_class;
    logic                   w_wr;
    logic                   w_rd;

    always_comb begin
        w_class.ch   = i_ch;
        w_class.kind = KIND_BAD;
        w_class.cls  = CLS_BAD;
        case (i_ch)
            CH_LPAR:  w_class.kind = KIND_LPAR;
            CH_RPAR:  w_class.kind = KIND_RPAR;
            CH_PLUS:  w_class.kind = KIND_PLUS;
            CH_MINUS: w_class.kind = KIND_MINUS;
            CH_STAR:  w_class.kind = KIND_MUL;
            CH_SLASH: w_class.kind = KIND_DIV;
            default:  w_class.kind = KIND_BAD;
        endcase
        if (i_action == ACT_END) begin
            w_class.cls  = CLS_END;
            w_class.kind = KIND_END;
        end else if (w_class.kind != KIND_BAD) begin
            w_class.cls = CLS_OP;
        end else begin
            case (i_ch) inside
                CH_NEWLINE:             w_class.cls = CLS_NEWLINE;
                [CH_DIGIT0:CH_DIGIT9]:  w_class.cls = CLS_DIGIT;
                CH_SPACE, [CH_TAB:CH_CR]: w_class.cls = CLS_SPACE;
                default:                w_class.cls = CLS_BAD;
            endcase
        end
    end

    assign o_full       = (r_count == IQ_CNT_BITS'(IQ_DEPTH));
    assign o_item_valid = (r_count != '0);
    assign o_item       = r_mem[r_rd_ptr];
    assign w_wr         = i_push && !o_full;
    assign w_rd         = i_item_pop && o_item_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= w_class;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + IQ_CNT_BITS'(w_wr) - IQ_CNT_BITS'(w_rd);
        end
    end

endmodule

// ----- sv/etok_back.sv -----
`timescale 1ns / 1ps
// etok_back: lexer engine; holds location, number accumulator and halt state.
// Depends on etok_pkg.
module etok_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_idx,
    input  logic [etok_pkg::CFG_BITS-1:0]   i_cfg_data,
    input  logic                            i_item_valid,
    input  etok_pkg::t_item                 i_item,
    output logic                            o_item_pop,
    output logic                            o_tok_valid,
    output etok_pkg::t_token                o_tok,
    input  logic                            i_tok_ready
);
    import etok_pkg::*;

    logic                  r_in_number, n_in_number;
    logic [VALUE_BITS-1:0] r_num_value, n_num_value;
    logic [POS_BITS-1:0]   r_num_len,   n_num_len;
    logic                  r_num_ovf,   n_num_ovf;
    logic [POS_BITS-1:0]   r_num_line,  n_num_line;
    logic [POS_BITS-1:0]   r_num_col,   n_num_col;
    logic [POS_BITS-1:0]   r_line,      n_line;
    logic [POS_BITS-1:0]   r_col,       n_col;
    logic                  r_halted,    n_halted;
    logic [POS_BITS-1:0]   r_first_line, n_first_line;
    logic [POS_BITS-1:0]   r_first_col,  n_first_col;

    logic [VALUE_BITS+3:0] w_acc;
    logic [3:0]            w_digit;
    logic                  w_own_token;

    assign w_digit     = i_item.ch[3:0];
    // value*10 + digit, four spare bits catch the overflow
    assign w_acc       = ({4'b0, r_num_value} << 3) + ({4'b0, r_num_value} << 1)
                       + (VALUE_BITS+4)'(w_digit);
    assign w_own_token = (i_item.cls == CLS_END) || (i_item.cls == CLS_OP)
                       || (i_item.cls == CLS_BAD);

    always_comb begin
        n_in_number  = r_in_number;
        n_num_value  = r_num_value;
        n_num_len    = r_num_len;
        n_num_ovf    = r_num_ovf;
        n_num_line   = r_num_line;
        n_num_col    = r_num_col;
        n_line       = r_line;
        n_col        = r_col;
        n_halted     = r_halted;
        n_first_line = r_first_line;
        n_first_col  = r_first_col;
        o_item_pop   = 1'b0;
        o_tok_valid  = 1'b0;
        o_tok        = '0;
        o_tok.line   = r_line;
        o_tok.column = r_col;
        o_tok.kind   = i_item.kind;
        if (i_item_valid) begin
            if (r_halted) begin
                o_item_pop = 1'b1;
            end else if (r_in_number && i_item.cls == CLS_DIGIT) begin
                o_item_pop = 1'b1;
                if (w_acc > {4'b0, VALUE_MAX}) begin
                    n_num_value = VALUE_MAX;
                    n_num_ovf   = 1'b1;
                end else begin
                    n_num_value = w_acc[VALUE_BITS-1:0];
                end
                if (r_num_len == POS_MAX) begin
                    n_num_ovf = 1'b1;
                end else begin
                    n_num_len = r_num_len + 1'b1;
                end
                n_col = sat_inc(r_col);
            end else if (r_in_number) begin
                // close the pending integer; the item stays for a second pass
                o_tok_valid   = 1'b1;
                o_tok.kind    = KIND_INT;
                o_tok.line    = r_num_line;
                o_tok.column  = r_num_col;
                o_tok.value   = r_num_value;
                o_tok.length  = r_num_len;
                o_tok.ovf     = r_num_ovf;
                o_tok.last    = !w_own_token;
                if (i_tok_ready) begin
                    n_in_number = 1'b0;
                end
            end else begin
                case (i_item.cls)
                    CLS_END: begin
                        o_tok_valid = 1'b1;
                        o_tok.kind  = KIND_END;
                        o_tok.last  = 1'b1;
                        if (i_tok_ready) begin
                            o_item_pop = 1'b1;
                            n_line     = r_first_line;
                            n_col      = r_first_col;
                        end
                    end
                    CLS_OP: begin
                        o_tok_valid  = 1'b1;
                        o_tok.length = POS_BITS'(1);
                        o_tok.last   = 1'b1;
                        if (i_tok_ready) begin
                            o_item_pop = 1'b1;
                            n_col      = sat_inc(r_col);
                        end
                    end
                    CLS_NEWLINE: begin
                        o_item_pop = 1'b1;
                        n_line     = sat_inc(r_line);
                        n_col      = r_first_col;
                    end
                    CLS_SPACE: begin
                        o_item_pop = 1'b1;
                        n_col      = sat_inc(r_col);
                    end
                    CLS_DIGIT: begin
                        o_item_pop  = 1'b1;
                        n_in_number = 1'b1;
                        n_num_value = VALUE_BITS'(w_digit);
                        n_num_len   = POS_BITS'(1);
                        n_num_ovf   = 1'b0;
                        n_num_line  = r_line;
                        n_num_col   = r_col;
                        n_col       = sat_inc(r_col);
                    end
                    CLS_BAD: begin
                        o_tok_valid    = 1'b1;
                        o_tok.kind     = KIND_BAD;
                        o_tok.length   = POS_BITS'(1);
                        o_tok.bad_char = i_item.ch;
                        o_tok.last     = 1'b1;
                        if (i_tok_ready) begin
                            o_item_pop = 1'b1;
                            n_halted   = 1'b1;
                        end
                    end
                    default: begin
                        o_item_pop = 1'b1;
                    end
                endcase
            end
        end
        // a register write also reloads its position counter
        if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FIRST_LINE: begin
                    n_first_line = i_cfg_data[POS_BITS-1:0];
                    n_line       = i_cfg_data[POS_BITS-1:0];
                end
                REG_FIRST_COLUMN: begin
                    n_first_col = i_cfg_data[POS_BITS-1:0];
                    n_col       = i_cfg_data[POS_BITS-1:0];
                end
                default: begin
                    n_first_line = r_first_line;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_number  <= 1'b0;
            r_num_value  <= '0;
            r_num_len    <= '0;
            r_num_ovf    <= 1'b0;
            r_num_line   <= '0;
            r_num_col    <= '0;
            r_line       <= POS_BITS'(1);
            r_col        <= '0;
            r_halted     <= 1'b0;
            r_first_line <= POS_BITS'(1);
            r_first_col  <= '0;
        end else begin
            r_in_number  <= n_in_number;
            r_num_value  <= n_num_value;
            r_num_len    <= n_num_len;
            r_num_ovf    <= n_num_ovf;
            r_num_line   <= n_num_line;
            r_num_col    <= n_num_col;
            r_line       <= n_line;
            r_col        <= n_col;
            r_halted     <= n_halted;
            r_first_line <= n_first_line;
            r_first_col  <= n_first_col;
        end
    end

    // halt is sticky until reset
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("halt state dropped without reset");

    // nothing is emitted once halted
    a_quiet_halted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |-> !o_tok_valid)
        else $error("token emitted while halted");

    // an integer token only ever closes a pending number
    a_int_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tok_valid && o_tok.kind == KIND_INT) |-> (r_in_number && !o_item_pop))
        else $error("integer token without pending number");

    // a delivered integer token clears the pending number
    a_int_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tok_valid && i_tok_ready && o_tok.kind == KIND_INT) |=> !r_in_number)
        else $error("pending number not cleared after integer token");

endmodule

// ----- sv/etok_out_queue.sv -----
`timescale 1ns / 1ps
// etok_out_queue: short token queue that decouples the engine from the result port.
// Depends on etok_pkg.
module etok_out_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  etok_pkg::t_token i_tok,
    output logic             o_ready,
    input  logic             i_pop,
    output logic             o_empty,
    output etok_pkg::t_token o_tok
);
    import etok_pkg::*;

    t_token                 r_mem [TQ_DEPTH];
    logic [TQ_PTR_BITS-1:0] r_wr_ptr;
    logic [TQ_PTR_BITS-1:0] r_rd_ptr;
    logic [TQ_CNT_BITS-1:0] r_count;
    logic                   w_wr;
    logic                   w_rd;

    assign o_ready = (r_count != TQ_CNT_BITS'(TQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_tok   = r_mem[r_rd_ptr];
    assign w_wr    = i_wr && o_ready;
    assign w_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + TQ_CNT_BITS'(w_wr) - TQ_CNT_BITS'(w_rd);
        end
    end

endmodule

// ----- sv/expression_tokenizer_unit.sv -----
`timescale 1ns / 1ps
// expression_tokenizer_unit: top level of the arithmetic expression tokenizer.
// Depends on etok_pkg, etok_front, etok_back, etok_out_queue.
//
//  channel   direction  handshake               payload
//  --------  ---------  ----------------------  -----------------------------------------
//  input     in         push / full             i_action, i_ch
//  result    out        empty / pop             o_token_kind .. o_last (8 fields)
//  config    in         i_cfg_we (no wait)      i_cfg_idx, i_cfg_data
//
// Flow: an input transaction is accepted in any cycle with push high and full low.
//   The engine retires one character per cycle while the token queue can take its token;
//   a character that terminates a pending integer first emits the integer token and then
//   takes its own action. A token is registered in the token queue and drives the result
//   ports at its head; an item's own token after a closed integer follows the integer token.
// Reset: synchronous, active low; clears both queues, the number accumulator and the
//   halt flag, and loads line 1 / column 0 into the location counters.
// Stalls: a 4-entry item queue sits between classifier and engine and a 4-entry token
//   queue before the result ports, so pop stalls only back up into full once both fill.
module expression_tokenizer_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input transactions
    input  logic                                push,
    output logic                                full,
    input  logic                                i_action,
    input  logic [etok_pkg::CH_BITS-1:0]        i_ch,
    // result transactions
    output logic                                empty,
    input  logic                                pop,
    output logic [etok_pkg::KIND_BITS-1:0]      o_token_kind,
    output logic [etok_pkg::POS_BITS-1:0]       o_token_line,
    output logic [etok_pkg::POS_BITS-1:0]       o_token_column,
    output logic [etok_pkg::VALUE_BITS-1:0]     o_int_value,
    output logic [etok_pkg::POS_BITS-1:0]       o_token_length,
    output logic                                o_int_overflow,
    output logic [etok_pkg::CH_BITS-1:0]        o_bad_char,
    output logic                                o_last,
    // configuration writes
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_idx,
    input  logic [etok_pkg::CFG_BITS-1:0]       i_cfg_data
);
    import etok_pkg::*;

    // classified items, front to engine
    logic   w_item_valid;
    t_item  w_item;
    logic   w_item_pop;
    // tokens, engine to result queue
    logic   w_tok_valid;
    t_token w_tok;
    logic   w_tok_ready;
    t_token w_head;

    // front end: classify each character as it arrives and queue it
    etok_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_action     (i_action),
        .i_ch         (i_ch),
        .o_item_valid (w_item_valid),
        .o_item       (w_item),
        .i_item_pop   (w_item_pop)
    );

    // back end: location tracking, integer accumulation, token generation
    etok_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_item_valid (w_item_valid),
        .i_item       (w_item),
        .o_item_pop   (w_item_pop),
        .o_tok_valid  (w_tok_valid),
        .o_tok        (w_tok),
        .i_tok_ready  (w_tok_ready)
    );

    // result queue: head entry drives the result ports while not empty
    etok_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_tok_valid),
        .i_tok   (w_tok),
        .o_ready (w_tok_ready),
        .i_pop   (pop),
        .o_empty (empty),
        .o_tok   (w_head)
    );

    assign o_token_kind   = w_head.kind;
    assign o_token_line   = w_head.line;
    assign o_token_column = w_head.column;
    assign o_int_value    = w_head.value;
    assign o_token_length = w_head.length;
    assign o_int_overflow = w_head.ovf;
    assign o_bad_char     = w_head.bad_char;
    assign o_last         = w_head.last;

endmodule
